>>> rtl/dual_arm_position_hold_assert.svh
// Assertion macros shared by the checker of the dual arm position hold block.
// Depends on nothing; included by the checker file only.
`ifndef DUAL_ARM_POSITION_HOLD_ASSERT_SVH
`define DUAL_ARM_POSITION_HOLD_ASSERT_SVH

// Checked only while reset is released.
`define DAH_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define DAH_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/dah_pkg.sv
// Shared types, register indexes and reset values of the dual arm position hold block.
// Used by the interfaces, the top level, dah_cfg and dah_step; depends on nothing.
`default_nettype none

package dah_pkg;

  localparam int unsigned POT_W   = 12;
  localparam int unsigned CFG_W   = 12;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned POS_W   = 13;

  typedef enum logic [IDX_W-1:0] {
    REG_MAX_POS       = 3'd0,
    REG_MIN_POS       = 3'd1,
    REG_SLOW_RANGE    = 3'd2,
    REG_CMD_THRESHOLD = 3'd3,
    REG_SPEED_STEP    = 3'd4,
    REG_UPDATE_PERIOD = 3'd5,
    REG_DEAD_BAND     = 3'd6
  } reg_idx_t;

  localparam logic [11:0] MAX_POS_RST       = 12'd3000;
  localparam logic [11:0] MIN_POS_RST       = 12'd1280;
  localparam logic [9:0]  SLOW_RANGE_RST    = 10'd10;
  localparam logic [6:0]  CMD_THRESHOLD_RST = 7'd90;
  localparam logic [6:0]  SPEED_STEP_RST    = 7'd20;
  localparam logic [7:0]  UPDATE_PERIOD_RST = 8'd50;
  localparam logic [9:0]  DEAD_BAND_RST     = 10'd10;

  typedef struct packed {
    logic [11:0] max_pos;
    logic [11:0] min_pos;
    logic [9:0]  slow_range;
    logic [6:0]  cmd_threshold;
    logic [6:0]  speed_step;
    logic [7:0]  update_period;
    logic [9:0]  dead_band;
  } cfg_t;

  typedef struct packed {
    logic signed [7:0]       drv_l;
    logic signed [7:0]       drv_r;
    logic [POS_W-1:0]        target;
    logic signed [POS_W-1:0] prev_l;
    logic signed [POS_W-1:0] prev_r;
    logic                    moving;
    logic                    holding;
    logic [7:0]              timer;
  } state_t;

endpackage

`default_nettype wire

>>> rtl/dah_if.sv
// Valid/ready channel interfaces for the input words and the result words.
// Depends on dah_pkg for the field widths.
`default_nettype none

interface dah_in_if;
  logic                        valid;
  logic                        ready;
  logic signed [7:0]           lift_cmd;
  logic [dah_pkg::POT_W-1:0]   pot_left;
  logic [dah_pkg::POT_W-1:0]   pot_right;
  logic                        ms_tick;

  modport source (output valid, output lift_cmd, output pot_left, output pot_right,
                  output ms_tick, input ready);
  modport sink   (input valid, input lift_cmd, input pot_left, input pot_right,
                  input ms_tick, output ready);
endinterface

interface dah_out_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] drive_left;
  logic signed [7:0] drive_right;

  modport source (output valid, output drive_left, output drive_right, input ready);
  modport sink   (input valid, input drive_left, input drive_right, output ready);
endinterface

`default_nettype wire

>>> rtl/dual_arm_position_hold.sv
// Top level of the dual arm position hold block: input register, state and result register.
// Depends on dah_pkg, dah_if (dah_in_if, dah_out_if), dah_cfg and dah_step.
//
// Usage:
//   in_ch carries one word per sample: lift_cmd, pot_left, pot_right and ms_tick.
//   out_ch returns exactly one word per input word: drive_left and drive_right,
//   the arm drive values after that sample has been applied.
//   Both channels use valid/ready; a word moves when valid and ready are high.
//   A word is first captured in the input register; from there it updates the
//   controller state and loads the result register.
//   Throughput is one word per cycle while out_ch.ready stays high, set by the
//   single result register stage that computes the whole update from the input
//   register and the state. When the receiver holds out_ch.ready low, the
//   result word holds and an empty input register takes one more word; then in_ch.ready drops.
//   Reset (rst_n low, synchronous) empties both registers, clears the drives,
//   target, errors, flags and timer, and loads the default configuration.
//   cfg_we writes cfg_wdata into the register at cfg_index on the clock edge;
//   write only while the block holds no words.
`default_nettype none

module dual_arm_position_hold (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  dah_in_if.sink                           in_ch,
  dah_out_if.source                        out_ch,
  input  wire logic                        cfg_we,
  input  wire logic [dah_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [dah_pkg::CFG_W-1:0]   cfg_wdata
);

  dah_pkg::cfg_t   cfg;
  dah_pkg::state_t st_r;
  dah_pkg::state_t st_nxt;

  logic                       in_v_r;
  logic signed [7:0]          cmd_r;
  logic [dah_pkg::POT_W-1:0]  pot_l_r;
  logic [dah_pkg::POT_W-1:0]  pot_r_r;
  logic                       tick_r;
  logic                       out_v_r;
  logic signed [7:0]          drv_l_r;
  logic signed [7:0]          drv_r_r;
  logic                       adv;
  logic                       in_rdy;

  dah_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dah_step u_step (
    .cfg       (cfg),
    .st        (st_r),
    .lift_cmd  (cmd_r),
    .pot_left  (pot_l_r),
    .pot_right (pot_r_r),
    .ms_tick   (tick_r),
    .st_nxt    (st_nxt)
  );

  // The result register can load when it is empty or being drained.
  assign adv    = !out_v_r || out_ch.ready;
  assign in_rdy = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      st_r    <= '0;
    end else begin
      if (in_rdy) in_v_r <= in_ch.valid;
      if (adv) out_v_r <= in_v_r;
      if (adv && in_v_r) st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_ch.valid) begin
      cmd_r   <= in_ch.lift_cmd;
      pot_l_r <= in_ch.pot_left;
      pot_r_r <= in_ch.pot_right;
      tick_r  <= in_ch.ms_tick;
    end
    if (adv && in_v_r) begin
      drv_l_r <= st_nxt.drv_l;
      drv_r_r <= st_nxt.drv_r;
    end
  end

  assign in_ch.ready        = in_rdy;
  assign out_ch.valid       = out_v_r;
  assign out_ch.drive_left  = drv_l_r;
  assign out_ch.drive_right = drv_r_r;

endmodule

`default_nettype wire

>>> rtl/dah_cfg.sv
// Configuration register file of the dual arm position hold block.
// Depends on dah_pkg for the register indexes, reset values and cfg_t.
`default_nettype none

module dah_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [dah_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [dah_pkg::CFG_W-1:0]   cfg_wdata,
  output dah_pkg::cfg_t                    cfg
);

  dah_pkg::cfg_t cfg_r;
  dah_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (dah_pkg::reg_idx_t'(cfg_index))
        dah_pkg::REG_MAX_POS:       cfg_nxt.max_pos       = cfg_wdata;
        dah_pkg::REG_MIN_POS:       cfg_nxt.min_pos       = cfg_wdata;
        dah_pkg::REG_SLOW_RANGE:    cfg_nxt.slow_range    = cfg_wdata[9:0];
        dah_pkg::REG_CMD_THRESHOLD: cfg_nxt.cmd_threshold = cfg_wdata[6:0];
        dah_pkg::REG_SPEED_STEP:    cfg_nxt.speed_step    = cfg_wdata[6:0];
        dah_pkg::REG_UPDATE_PERIOD: cfg_nxt.update_period = cfg_wdata[7:0];
        dah_pkg::REG_DEAD_BAND:     cfg_nxt.dead_band     = cfg_wdata[9:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_pos       <= dah_pkg::MAX_POS_RST;
      cfg_r.min_pos       <= dah_pkg::MIN_POS_RST;
      cfg_r.slow_range    <= dah_pkg::SLOW_RANGE_RST;
      cfg_r.cmd_threshold <= dah_pkg::CMD_THRESHOLD_RST;
      cfg_r.speed_step    <= dah_pkg::SPEED_STEP_RST;
      cfg_r.update_period <= dah_pkg::UPDATE_PERIOD_RST;
      cfg_r.dead_band     <= dah_pkg::DEAD_BAND_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> rtl/dah_step.sv
// Next-state logic for one word: move drives, release clamp and hold correction.
// Depends on dah_pkg for cfg_t and state_t.
`default_nettype none

module dah_step (
  input  wire dah_pkg::cfg_t               cfg,
  input  wire dah_pkg::state_t             st,
  input  wire logic signed [7:0]           lift_cmd,
  input  wire logic [dah_pkg::POT_W-1:0]   pot_left,
  input  wire logic [dah_pkg::POT_W-1:0]   pot_right,
  input  wire logic                        ms_tick,
  output dah_pkg::state_t                  st_nxt
);

  function automatic logic signed [7:0] sat_drive(input logic signed [8:0] v);
    logic signed [7:0] r;
    if (v > 9'sd127)       r = 8'sd127;
    else if (v < -9'sd127) r = -8'sd127;
    else                   r = v[7:0];
    return r;
  endfunction

  function automatic logic signed [7:0] lower_drive(input logic [11:0] pot,
                                                    input logic [11:0] min_pos,
                                                    input logic [9:0] slow);
    logic signed [7:0] r;
    if (pot < min_pos)                              r = 8'sd0;
    else if ({1'b0, pot} < {1'b0, min_pos} + {3'b000, slow}) r = -8'sd63;
    else                                            r = -8'sd127;
    return r;
  endfunction

  function automatic logic signed [7:0] raise_drive(input logic [11:0] pot,
                                                    input logic [11:0] max_pos,
                                                    input logic [9:0] slow);
    logic signed [12:0] knee;
    logic signed [7:0]  r;
    knee = $signed({1'b0, max_pos}) - $signed({3'b000, slow});
    if (pot > max_pos)                  r = 8'sd10;
    else if ($signed({1'b0, pot}) > knee) r = 8'sd63;
    else                                r = 8'sd127;
    return r;
  endfunction

  function automatic logic signed [7:0] add_step(input logic signed [7:0] drv,
                                                 input logic [6:0] step);
    return sat_drive($signed({drv[7], drv}) + $signed({2'b00, step}));
  endfunction

  function automatic logic signed [7:0] sub_step(input logic signed [7:0] drv,
                                                 input logic [6:0] step);
    return sat_drive($signed({drv[7], drv}) - $signed({2'b00, step}));
  endfunction

  // Error is below the band: push up if it got worse, back off if it improved.
  function automatic logic signed [7:0] correct_low(input logic signed [12:0] err,
                                                    input logic signed [12:0] prev,
                                                    input logic [11:0] pot,
                                                    input logic signed [7:0] drv,
                                                    input dah_pkg::cfg_t c);
    logic signed [7:0] r;
    r = drv;
    if (err < prev) begin
      if (pot < c.max_pos) r = add_step(drv, c.speed_step);
    end else if (drv > 8'sd0) begin
      r = sub_step(drv, c.speed_step);
    end
    return r;
  endfunction

  function automatic logic signed [7:0] correct_high(input logic signed [12:0] err,
                                                     input logic signed [12:0] prev,
                                                     input logic [11:0] pot,
                                                     input logic signed [7:0] drv,
                                                     input dah_pkg::cfg_t c);
    logic signed [7:0] r;
    r = drv;
    if (err > prev) begin
      if (pot > c.min_pos) r = sub_step(drv, c.speed_step);
    end else if (drv > 8'sd0) begin
      r = add_step(drv, c.speed_step);
    end
    return r;
  endfunction

  // The millisecond timer stops at its top value.
  function automatic logic timer_inc_ok();
    return st.timer != 8'hFF;
  endfunction

  logic [7:0]                     timer_inc;
  logic signed [7:0]              thr_s;
  logic                           cmd_low;
  logic                           cmd_high;
  logic [12:0]                    pot_sum;
  logic [12:0]                    move_target;
  logic [12:0]                    clamp_target;
  logic signed [12:0]             err_l;
  logic signed [12:0]             err_r;
  logic signed [12:0]             rel_err_l;
  logic signed [12:0]             rel_err_r;
  logic signed [12:0]             db_s;

  always_comb begin
    timer_inc = (ms_tick && timer_inc_ok()) ? st.timer + 8'd1 : st.timer;
    thr_s     = $signed({1'b0, cfg.cmd_threshold});
    cmd_low   = lift_cmd <= -thr_s;
    cmd_high  = lift_cmd >= thr_s;
    pot_sum     = {1'b0, pot_left} + {1'b0, pot_right};
    move_target = {1'b0, pot_sum[12:1]} + 13'd100;

    if (st.target < {1'b0, cfg.min_pos})      clamp_target = {1'b0, cfg.min_pos};
    else if (st.target > {1'b0, cfg.max_pos}) clamp_target = {1'b0, cfg.max_pos};
    else                                      clamp_target = st.target;

    // Clamped targets are at most 4095, so those differences fit in 13 bits.
    rel_err_l = $signed({1'b0, pot_left})  - $signed(clamp_target);
    rel_err_r = $signed({1'b0, pot_right}) - $signed(clamp_target);
    err_l     = $signed({1'b0, pot_left})  - $signed(st.target);
    err_r     = $signed({1'b0, pot_right}) - $signed(st.target);
    db_s      = $signed({3'b000, cfg.dead_band});

    st_nxt       = st;
    st_nxt.timer = timer_inc;

    if (cmd_low || cmd_high) begin
      if (cmd_low) begin
        st_nxt.drv_l = lower_drive(pot_left, cfg.min_pos, cfg.slow_range);
        st_nxt.drv_r = lower_drive(pot_right, cfg.min_pos, cfg.slow_range);
      end else begin
        st_nxt.drv_l = raise_drive(pot_left, cfg.max_pos, cfg.slow_range);
        st_nxt.drv_r = raise_drive(pot_right, cfg.max_pos, cfg.slow_range);
      end
      st_nxt.target = move_target;
      st_nxt.moving = 1'b1;
    end else if (st.moving) begin
      st_nxt.moving  = 1'b0;
      st_nxt.target  = clamp_target;
      st_nxt.drv_l   = 8'sd0;
      st_nxt.drv_r   = 8'sd0;
      st_nxt.timer   = 8'd0;
      st_nxt.holding = 1'b1;
      st_nxt.prev_l  = rel_err_l;
      st_nxt.prev_r  = rel_err_r;
    end else if (st.holding && (timer_inc > cfg.update_period)) begin
      st_nxt.timer = 8'd0;
      if (err_l < -db_s) begin
        st_nxt.drv_l = correct_low(err_l, st.prev_l, pot_left, st.drv_l, cfg);
      end else if (err_r < -db_s) begin
        st_nxt.drv_r = correct_low(err_r, st.prev_r, pot_right, st.drv_r, cfg);
      end else if (err_l > db_s) begin
        st_nxt.drv_l = correct_high(err_l, st.prev_l, pot_left, st.drv_l, cfg);
      end else if (err_r > db_s) begin
        st_nxt.drv_r = correct_high(err_r, st.prev_r, pot_right, st.drv_r, cfg);
      end
      st_nxt.prev_l = err_l;
      st_nxt.prev_r = err_r;
    end
  end

endmodule

`default_nettype wire

>>> rtl/dah_checker.sv
// Port-level checker for the dual arm position hold block, bound to its top level.
// Depends on dual_arm_position_hold_assert.svh for the assertion macros.
`default_nettype none

`include "dual_arm_position_hold_assert.svh"

module dah_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic signed [7:0] drive_left,
  input wire logic signed [7:0] drive_right
);

  // A reset cycle leaves no result word behind.
  `DAH_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result valid after reset")

  // Drives saturate at plus or minus 127, so the most negative code never shows.
  `DAH_ASSERT(a_drive_range, clk, rst_n, out_valid |-> (drive_left != -8'sd128) && (drive_right != -8'sd128), "drive out of range")

  // After a word is taken, the input side may only block behind a waiting result.
  `DAH_ASSERT(a_no_false_stall, clk, rst_n, (in_valid && in_ready) |=> (in_ready || out_valid), "input stalled with empty output")

  // A stalled result word holds its payload.
  `DAH_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(drive_left) && $stable(drive_right)), "stalled result changed")

endmodule

bind dual_arm_position_hold dah_checker u_dah_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .drive_left  (out_ch.drive_left),
  .drive_right (out_ch.drive_right)
);

`default_nettype wire
